// ===== src/sha1bh_pkg.sv =====
// Shared constants, command struct and round helpers for the SHA-1 block hasher.
// No dependencies; used by sha1bh_ctrl, sha1bh_datapath and sha1_block_hash.
`default_nettype none

package sha1bh_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;
    localparam int ROUNDS_PHASE = 20;
    localparam int DIGEST_WORDS = 5;

    // Round function groups
    localparam logic [1:0] PH_CHOOSE = 2'd0;
    localparam logic [1:0] PH_PAR_A  = 2'd1;
    localparam logic [1:0] PH_MAJ    = 2'd2;
    localparam logic [1:0] PH_PAR_B  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;     // shift a message word into the schedule
        logic       start;    // copy the chaining value into a..e
        logic       round;    // run one compression round
        logic       expand;   // round uses an expanded schedule word
        logic [1:0] phase;    // round function group
        logic       add;      // fold a..e into the chaining value
        logic       clear;    // return the chaining value to the initial values
        logic [2:0] out_idx;  // chaining word shown on the output
    } t_dp_cmd;

    function automatic logic [WORD_W-1:0] init_chain(input logic [2:0] idx);
        logic [WORD_W-1:0] v;
        unique case (idx)
            3'd0:    v = 32'h6745_2301;
            3'd1:    v = 32'hefcd_ab89;
            3'd2:    v = 32'h98ba_dcfe;
            3'd3:    v = 32'h1032_5476;
            3'd4:    v = 32'hc3d2_e1f0;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [1:0] phase);
        logic [WORD_W-1:0] v;
        unique case (phase)
            PH_CHOOSE: v = 32'h5a82_7999;
            PH_PAR_A:  v = 32'h6ed9_eba1;
            PH_MAJ:    v = 32'h8f1b_bcdc;
            PH_PAR_B:  v = 32'hca62_c1d6;
            default:   v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(input logic [1:0] phase,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] v;
        unique case (phase)
            PH_CHOOSE: v = (b & c) | (~b & d);
            PH_MAJ:    v = (b & c) | (b & d) | (c & d);
            PH_PAR_A,
            PH_PAR_B:  v = b ^ c ^ d;
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/sha1bh_ctrl.sv =====
// Sequencer for the SHA-1 block hasher: word count, round count, digest output.
// Depends on sha1bh_pkg; drives sha1bh_datapath through t_dp_cmd.
`default_nettype none

module sha1bh_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_final,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [2:0]             o_out_idx,
    output logic                   o_out_last,
    output sha1bh_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [3:0] LAST_WORD  = 4'(sha1bh_pkg::BLOCK_WORDS - 1);
    localparam logic [6:0] LAST_ROUND = 7'(sha1bh_pkg::ROUNDS - 1);
    localparam logic [2:0] LAST_OUT   = 3'(sha1bh_pkg::DIGEST_WORDS - 1);

    logic [1:0] r_state, n_state;
    logic [3:0] r_word_cnt, n_word_cnt;
    logic [6:0] r_round, n_round;
    logic [2:0] r_out_idx, n_out_idx;
    logic       r_final, n_final;

    logic in_fire;
    logic out_fire;
    logic [1:0] phase;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;
    assign o_out_idx   = r_out_idx;
    assign o_out_last  = (r_out_idx == LAST_OUT);

    always_comb begin
        if (r_round < 7'(sha1bh_pkg::ROUNDS_PHASE)) begin
            phase = sha1bh_pkg::PH_CHOOSE;
        end else if (r_round < 7'(2 * sha1bh_pkg::ROUNDS_PHASE)) begin
            phase = sha1bh_pkg::PH_PAR_A;
        end else if (r_round < 7'(3 * sha1bh_pkg::ROUNDS_PHASE)) begin
            phase = sha1bh_pkg::PH_MAJ;
        end else begin
            phase = sha1bh_pkg::PH_PAR_B;
        end
    end

    always_comb begin
        o_cmd.load    = in_fire;
        o_cmd.start   = in_fire && (r_word_cnt == LAST_WORD);
        o_cmd.round   = (r_state == ST_ROUND);
        o_cmd.expand  = (r_round >= 7'(sha1bh_pkg::BLOCK_WORDS));
        o_cmd.phase   = phase;
        o_cmd.add     = (r_state == ST_ADD);
        o_cmd.clear   = out_fire && (r_out_idx == LAST_OUT);
        o_cmd.out_idx = r_out_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_word_cnt = r_word_cnt;
        n_round    = r_round;
        n_out_idx  = r_out_idx;
        n_final    = r_final;
        unique case (r_state)
            ST_LOAD: begin
                if (in_fire) begin
                    n_word_cnt = r_word_cnt + 4'd1;
                    if (r_word_cnt == LAST_WORD) begin
                        // only the flag on the block's closing word counts
                        n_final = i_in_final;
                        n_round = '0;
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_out_idx = '0;
                n_state   = r_final ? ST_OUT : ST_LOAD;
            end
            ST_OUT: begin
                if (out_fire) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == LAST_OUT) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_word_cnt <= '0;
            r_round    <= '0;
            r_out_idx  <= '0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_word_cnt <= n_word_cnt;
            r_round    <= n_round;
            r_out_idx  <= n_out_idx;
            r_final    <= n_final;
        end
    end

endmodule

`default_nettype wire

// ===== src/sha1bh_datapath.sv =====
// SHA-1 datapath: 16-word schedule window, working variables a..e, chaining value.
// Depends on sha1bh_pkg; commanded by sha1bh_ctrl.
`default_nettype none

module sha1bh_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sha1bh_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [sha1bh_pkg::WORD_W-1:0]       i_word,
    output logic [sha1bh_pkg::WORD_W-1:0]            o_digest
);

    localparam int W = sha1bh_pkg::WORD_W;
    localparam int N = sha1bh_pkg::BLOCK_WORDS;
    localparam int H = sha1bh_pkg::DIGEST_WORDS;

    // r_w[0] holds the oldest word W[t-16], r_w[N-1] the newest
    logic [W-1:0] r_w [N];
    logic [W-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [W-1:0] r_h [H];

    logic [W-1:0] mix;
    logic [W-1:0] wr;
    logic [W-1:0] shift_in;
    logic [W-1:0] t_sum;

    assign mix      = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign wr       = i_cmd.expand ? {mix[W-2:0], mix[W-1]} : r_w[0];
    assign shift_in = i_cmd.load ? i_word : wr;
    assign t_sum    = {r_a[W-6:0], r_a[W-1:W-5]}
                    + sha1bh_pkg::round_f(i_cmd.phase, r_b, r_c, r_d)
                    + r_e + sha1bh_pkg::round_k(i_cmd.phase) + wr;

    assign o_digest = r_h[i_cmd.out_idx];

    // schedule window: shift on a load or a round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.round) begin
            for (int i = 0; i < N - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[N-1] <= shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[W-1:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < H; i++) begin
                r_h[i] <= sha1bh_pkg::init_chain(3'(i));
            end
        end else if (i_cmd.add) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

endmodule

`default_nettype wire

// ===== src/sha1_block_hash.sv =====
// Top level of the SHA-1 block hasher: stream ports, controller and datapath.
// Depends on sha1bh_pkg, sha1bh_ctrl and sha1bh_datapath.
//
// Usage:
//   Slave stream takes the padded message, one 32-bit big-endian word per
//   beat, sixteen beats per 512-bit block. tuser marks the final block; only
//   its value on the sixteenth beat of a block is looked at.
//   After the sixteenth beat the block runs 80 rounds, one per cycle, then
//   folds the result into the chaining value. Beats are taken only while
//   loading, so the next block cannot start until the current one has been
//   folded in, as all rounds share the single round unit.
//   For a final block the master stream then shows h0..h4, one beat each,
//   tuser giving the word index and tlast set on h4. The first digest beat
//   is valid once the fold is done and can leave at the next edge.
//   A stalled master holds the current digest beat and keeps the slave side
//   closed; after h4 leaves, the chaining value returns to the initial
//   values and loading resumes.
//   Reset (synchronous, active low) clears the word count, empties the
//   output and restores the initial chaining value.
`default_nettype none

module sha1_block_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] message_word
    input  wire logic        i_s_axis_tuser,   // [0] final_block
    // master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       o_m_axis_tuser,   // [2:0] word_index
    output logic             o_m_axis_tlast    // last_word
);

    sha1bh_pkg::t_dp_cmd cmd;

    sha1bh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_final  (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_idx   (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast),
        .o_cmd       (cmd)
    );

    sha1bh_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_word   (i_s_axis_tdata),
        .o_digest (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
